// File: rtl/sbdr_pkg.sv
package sbdr_pkg;

  localparam int ROW_ENTRIES = 8;
  localparam int NUM_DIFF    = 16;
  localparam int NIB_W       = 4;
  localparam int CNT_W       = 5;
  localparam int POS_W       = 3;
  localparam int LEN_W       = 4;
  localparam int RANK_W      = 4;
  localparam int TOTAL_W     = 5;
  localparam int SBOX_W      = NUM_DIFF * NIB_W;
  localparam int MAXW_W      = 3;
  localparam int REG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [NIB_W-1:0] nib_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SBOX        = 2'd0,
    REG_MAX_WEIGHT  = 2'd1,
    REG_USE_INVERSE = 2'd2
  } reg_idx_t;

  // one finished row, sorted by rank, as it travels from front to back
  typedef struct packed {
    nib_t [ROW_ENTRIES-1:0] dy;
    cnt_t [ROW_ENTRIES-1:0] cnt;
    logic [LEN_W-1:0]       len;
    logic                   trunc;
  } row_t;

  // queue status seen by the back end
  typedef struct packed {
    logic valid;
  } q_rd_t;

endpackage

// File: rtl/sbdr_front.sv
module sbdr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  sbdr_pkg::nib_t                   input_difference,
  input  logic [sbdr_pkg::SBOX_W-1:0]      sbox_table,
  input  logic [sbdr_pkg::MAXW_W-1:0]      max_weight,
  input  logic                             use_inverse,
  output logic                             q_push,
  output sbdr_pkg::row_t                   q_data,
  input  logic                             q_full
);
  import sbdr_pkg::*;

  function automatic logic [MAXW_W-1:0] weight4(input nib_t v);
    weight4 = MAXW_W'(v[0]) + MAXW_W'(v[1]) + MAXW_W'(v[2]) + MAXW_W'(v[3]);
  endfunction

  // stage 1: table and table permuted by dx
  logic                              v1;
  logic [NUM_DIFF-1:0][NIB_W-1:0]    tab1, perm1;
  // stage 2: counts and keep mask
  logic                              v2;
  cnt_t [NUM_DIFF-1:0]               cnt2;
  logic [NUM_DIFF-1:0]               keep2;
  // stage 3: ranks
  logic                              v3;
  cnt_t [NUM_DIFF-1:0]               cnt3;
  logic [NUM_DIFF-1:0]               keep3;
  logic [NUM_DIFF-1:0][RANK_W-1:0]   rank3;
  logic [TOTAL_W-1:0]                total3;

  logic                              rdy1, rdy2, rdy3;
  logic [NUM_DIFF-1:0][NIB_W-1:0]    tab_c, perm_c;
  cnt_t [NUM_DIFF-1:0]               cnt_c;
  logic [NUM_DIFF-1:0]               keep_c;
  logic [NUM_DIFF-1:0][RANK_W-1:0]   rank_c;
  logic [TOTAL_W-1:0]                total_c;
  row_t                              row_c;

  assign rdy3   = !v3 || !q_full;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;
  assign full   = !rdy1;
  assign q_push = v3 && !q_full;
  assign q_data = row_c;

  // S-box or its inverse; for the inverse a later x overwrites an earlier one
  always_comb begin
    for (int v = 0; v < NUM_DIFF; v++) begin
      tab_c[v] = use_inverse ? '0 : sbox_table[v*NIB_W +: NIB_W];
    end
    if (use_inverse) begin
      for (int x = 0; x < NUM_DIFF; x++) begin
        for (int v = 0; v < NUM_DIFF; v++) begin
          if (sbox_table[x*NIB_W +: NIB_W] == NIB_W'(v)) begin
            tab_c[v] = NIB_W'(x);
          end
        end
      end
    end
  end

  // x -> x ^ dx as four conditional swap layers
  always_comb begin
    logic [NUM_DIFF-1:0][NIB_W-1:0] lyr [NIB_W+1];
    lyr[0] = tab_c;
    for (int b = 0; b < NIB_W; b++) begin
      for (int x = 0; x < NUM_DIFF; x++) begin
        lyr[b+1][x] = input_difference[b] ? lyr[b][x ^ (1 << b)] : lyr[b][x];
      end
    end
    perm_c = lyr[NIB_W];
  end

  // histogram of output differences, then filter
  always_comb begin
    for (int dy = 0; dy < NUM_DIFF; dy++) begin
      cnt_c[dy] = '0;
      for (int x = 0; x < NUM_DIFF; x++) begin
        cnt_c[dy] = cnt_c[dy] + CNT_W'((tab1[x] ^ perm1[x]) == NIB_W'(dy));
      end
      keep_c[dy] = (cnt_c[dy] != '0) && (weight4(NIB_W'(dy)) <= max_weight);
    end
  end

  // rank = number of kept entries ahead: higher count, or same count and lower dy
  always_comb begin
    total_c = '0;
    for (int i = 0; i < NUM_DIFF; i++) begin
      total_c   = total_c + TOTAL_W'(keep2[i]);
      rank_c[i] = '0;
      for (int j = 0; j < NUM_DIFF; j++) begin
        if (keep2[j] && ((cnt2[j] > cnt2[i]) || ((cnt2[j] == cnt2[i]) && (j < i)))) begin
          rank_c[i] = rank_c[i] + RANK_W'(1);
        end
      end
    end
  end

  // place each kept entry in its slot; ranks are unique
  always_comb begin
    for (int k = 0; k < ROW_ENTRIES; k++) begin
      row_c.dy[k]  = '0;
      row_c.cnt[k] = '0;
      for (int i = 0; i < NUM_DIFF; i++) begin
        if (keep3[i] && (rank3[i] == RANK_W'(k))) begin
          row_c.dy[k]  = row_c.dy[k] | NIB_W'(i);
          row_c.cnt[k] = row_c.cnt[k] | cnt3[i];
        end
      end
    end
    row_c.trunc = (total3 > TOTAL_W'(ROW_ENTRIES));
    row_c.len   = row_c.trunc ? LEN_W'(ROW_ENTRIES) : LEN_W'(total3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= push;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && push) begin
      tab1  <= tab_c;
      perm1 <= perm_c;
    end
    if (rdy2) begin
      cnt2  <= cnt_c;
      keep2 <= keep_c;
    end
    if (rdy3) begin
      cnt3   <= cnt2;
      keep3  <= keep2;
      rank3  <= rank_c;
      total3 <= total_c;
    end
  end

endmodule

// File: rtl/sbdr_queue.sv
module sbdr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  sbdr_pkg::row_t    wr_data,
  output logic              full,
  output sbdr_pkg::q_rd_t   rd_st,
  input  logic              rd_pop,
  output sbdr_pkg::row_t    rd_data
);
  import sbdr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  row_t               mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_QW-1:0]  count;
  logic               do_wr, do_rd;

  assign full        = (count == CNT_QW'(QUEUE_DEPTH));
  assign rd_st.valid = (count != '0);
  assign rd_data     = mem[rd_ptr];
  assign do_wr       = wr_en && !full;
  assign do_rd       = rd_pop && rd_st.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_QW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/sbdr_back.sv
module sbdr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sbdr_pkg::q_rd_t               q_st,
  input  sbdr_pkg::row_t                q_data,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output sbdr_pkg::nib_t                output_difference,
  output sbdr_pkg::cnt_t                pair_count,
  output logic [sbdr_pkg::POS_W-1:0]    entry_position,
  output logic                          entry_valid,
  output logic [sbdr_pkg::LEN_W-1:0]    row_length,
  output logic                          row_truncated,
  output logic                          last_entry
);
  import sbdr_pkg::*;

  logic              o_valid;
  logic [POS_W-1:0]  idx;
  logic              load, row_empty, last_c;

  assign empty     = !o_valid;
  assign load      = q_st.valid && (!o_valid || pop);
  assign row_empty = (q_data.len == '0);
  assign last_c    = row_empty || ((LEN_W'(idx) + LEN_W'(1)) == q_data.len);
  assign q_pop     = load && last_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      idx     <= '0;
    end else if (load) begin
      o_valid <= 1'b1;
      idx     <= last_c ? '0 : idx + POS_W'(1);
    end else if (pop) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_entry <= last_c;
      if (row_empty) begin
        output_difference <= '0;
        pair_count        <= '0;
        entry_position    <= '0;
        entry_valid       <= 1'b0;
        row_length        <= '0;
        row_truncated     <= 1'b0;
      end else begin
        output_difference <= q_data.dy[idx];
        pair_count        <= q_data.cnt[idx];
        entry_position    <= idx;
        entry_valid       <= 1'b1;
        row_length        <= q_data.len;
        row_truncated     <= q_data.trunc;
      end
    end
  end

endmodule

// File: rtl/sbox_ddt_row_sorted_core.sv
// Sorted difference-table row for a 4-bit S-box.
// Input queue: push / full carry one input_difference (dx); a transfer happens
// on a rising edge with push high and full low.
// Result queue: while empty is low the oldest result sits on the result ports;
// pop high at a rising edge with empty low transfers it.
// Config: cfg_write with cfg_index / cfg_data writes sbox_table (0), max_weight
// (1) or use_inverse (2) at the edge; other indexes are dropped. Write only
// while idle.
// Each row yields its kept (dy, count) pairs, highest count first, ties by
// ascending dy, at most eight, last_entry on the final one; an empty row yields
// one result with entry_valid low.
// Path: the first result of a row passes the 3-stage front (table/permute,
// histogram, rank), then the queue write, then the back-end register.
// Throughput: the back end emits one result per cycle while pop is high and a
// row waits at the head of the 2-row queue; a row yields max(row_length, 1)
// results. The front takes a new dx every cycle while the queue has room.
// Reset (synchronous rst): queue and pipeline emptied, empty high, registers
// back to their defaults. A stalled receiver holds the result; the queue then
// fills and full rises, backing up the input side.
module sbox_ddt_row_sorted_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  sbdr_pkg::nib_t                    input_difference,
  input  logic                              pop,
  output logic                              empty,
  output sbdr_pkg::nib_t                    output_difference,
  output sbdr_pkg::cnt_t                    pair_count,
  output logic [sbdr_pkg::POS_W-1:0]        entry_position,
  output logic                              entry_valid,
  output logic [sbdr_pkg::LEN_W-1:0]        row_length,
  output logic                              row_truncated,
  output logic                              last_entry,
  input  logic                              cfg_write,
  input  logic [sbdr_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [sbdr_pkg::SBOX_W-1:0]       cfg_data
);
  import sbdr_pkg::*;

  logic [SBOX_W-1:0] sbox_table;
  logic [MAXW_W-1:0] max_weight;
  logic              use_inverse;

  logic   fq_push, fq_full, q_pop;
  row_t   fq_data, q_data;
  q_rd_t  q_st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sbox_table  <= 64'h0123_4567_89AB_CDEF;
      max_weight  <= MAXW_W'(4);
      use_inverse <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SBOX:        sbox_table  <= cfg_data;
        REG_MAX_WEIGHT:  max_weight  <= cfg_data[MAXW_W-1:0];
        REG_USE_INVERSE: use_inverse <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: build row, sort, hand to queue
  sbdr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .input_difference (input_difference),
    .sbox_table       (sbox_table),
    .max_weight       (max_weight),
    .use_inverse      (use_inverse),
    .q_push           (fq_push),
    .q_data           (fq_data),
    .q_full           (fq_full)
  );

  // decoupling queue, two rows deep
  sbdr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_push),
    .wr_data (fq_data),
    .full    (fq_full),
    .rd_st   (q_st),
    .rd_pop  (q_pop),
    .rd_data (q_data)
  );

  // back: walk the head row one result per transfer
  sbdr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_st              (q_st),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .output_difference (output_difference),
    .pair_count        (pair_count),
    .entry_position    (entry_position),
    .entry_valid       (entry_valid),
    .row_length        (row_length),
    .row_truncated     (row_truncated),
    .last_entry        (last_entry)
  );

endmodule

// File: rtl/sbdr_check.sv
module sbdr_check (
  input logic       clk,
  input logic       rst,
  input logic       pop,
  input logic       empty,
  input logic [4:0] pair_count,
  input logic [2:0] entry_position,
  input logic       entry_valid,
  input logic [3:0] row_length,
  input logic       last_entry
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_empty_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && !entry_valid) |-> (last_entry && row_length == 4'd0 && pair_count == 5'd0))
    else $error("bad empty-row marker");

  a_entry_sane: assert property (@(posedge clk) disable iff (rst)
    (!empty && entry_valid) |->
      (pair_count != 5'd0 && ({1'b0, entry_position} < row_length)))
    else $error("entry fields out of range");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (!empty && entry_valid && last_entry) |->
      (({1'b0, entry_position} + 4'd1) == row_length))
    else $error("last entry not at end of row");

  a_next_pos: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !last_entry) |=>
      (!empty && entry_position == ($past(entry_position) + 3'd1)))
    else $error("row entries not back to back");

endmodule

bind sbox_ddt_row_sorted_core sbdr_check u_sbdr_check (
  .clk            (clk),
  .rst            (rst),
  .pop            (pop),
  .empty          (empty),
  .pair_count     (pair_count),
  .entry_position (entry_position),
  .entry_valid    (entry_valid),
  .row_length     (row_length),
  .last_entry     (last_entry)
);
